>>> hw/rtl/swp_pkg.sv
// Package with shared types, widths and the helper function of the scroll window block.
package swp_pkg;

  localparam int unsigned FieldW       = 16;
  localparam int unsigned DivW         = FieldW + 1;
  localparam int unsigned Lanes        = 4;
  localparam int unsigned IndexBitsDef = 16;

  // Divider lanes.
  localparam int unsigned LaneCap = 0;
  localparam int unsigned LaneCnt = 1;
  localparam int unsigned LaneWin = 2;
  localparam int unsigned LaneSel = 3;

  typedef struct packed {
    logic                            op;
    logic                            zero;
    logic                            grid;
    logic [FieldW-1:0]               list_res;
    logic [FieldW-1:0]               cols;
    logic [Lanes-1:0][DivW-1:0]      dvd;
  } item_t;

  // Lowers a list window so that no blank space follows the last item.
  function automatic logic [FieldW-1:0] tail_limit(input logic [FieldW-1:0] first,
                                                   input logic [FieldW-1:0] cap,
                                                   input logic [FieldW-1:0] cnt);
    logic [FieldW-1:0] lim;
    lim = cnt - cap;
    if (cnt <= cap) return '0;
    return (first > lim) ? lim : first;
  endfunction

endpackage

>>> hw/rtl/swp_if.sv
// Channel interfaces of the scroll window block.
interface swp_in_if;
  logic        valid;
  logic        ready;
  logic        op;
  logic [15:0] window_start;
  logic [15:0] selected_index;
  logic [15:0] capacity;
  logic [15:0] item_count;
  logic [15:0] column_count;
  modport source (output valid, op, window_start, selected_index, capacity, item_count,
                  column_count, input ready);
  modport sink (input valid, op, window_start, selected_index, capacity, item_count,
                column_count, output ready);
endinterface

interface swp_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] new_window_start;
  modport source (output valid, new_window_start, input ready);
  modport sink (input valid, new_window_start, output ready);
endinterface

>>> hw/rtl/swp_front.sv
// Front end: accepts beats, masks and clamps the fields, settles list cases.
module swp_front import swp_pkg::*; #(
  parameter int unsigned IndexBits = IndexBitsDef
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  swp_in_if.sink in_i,
  output logic   vld_o,
  output item_t  item_o,
  input  logic   take_i
);

  localparam logic [FieldW-1:0] IdxMask =
    (IndexBits >= FieldW) ? {FieldW{1'b1}} : FieldW'((64'd1 << IndexBits) - 64'd1);

  logic [FieldW-1:0] w, s, c, n, k, sc, h, lres;
  logic [DivW-1:0]   wc;
  logic              vld_q;
  item_t             item_d, item_q;

  always_comb begin
    w  = in_i.window_start & IdxMask;
    s  = in_i.selected_index & IdxMask;
    c  = in_i.capacity & IdxMask;
    n  = in_i.item_count & IdxMask;
    k  = in_i.column_count & IdxMask;
    sc = (s >= n) ? n - 1'b1 : s;
    wc = {1'b0, w} + {1'b0, c};
    h  = c >> 1;
    if (in_i.op) begin
      lres = (sc < h) ? '0 : tail_limit(sc - h, c, n);
    end else if (sc < w) begin
      lres = tail_limit(sc, c, n);
    end else if ({1'b0, sc} >= wc) begin
      lres = tail_limit(sc - c + 1'b1, c, n);
    end else begin
      lres = tail_limit(w, c, n);
    end
    item_d.op       = in_i.op;
    item_d.zero     = (c == '0) || (n == '0);
    item_d.grid     = k > FieldW'(1);
    item_d.list_res = lres;
    item_d.cols     = item_d.grid ? k : FieldW'(1);
    item_d.dvd[LaneCap] = {1'b0, c};
    item_d.dvd[LaneCnt] = {1'b0, n} + {1'b0, k} - DivW'(1);
    item_d.dvd[LaneWin] = {1'b0, w};
    item_d.dvd[LaneSel] = {1'b0, sc};
  end

  assign in_i.ready = !vld_q || take_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (in_i.ready) begin
      vld_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      item_q <= item_d;
    end
  end

  assign vld_o  = vld_q;
  assign item_o = item_q;

endmodule

>>> hw/rtl/swp_fifo.sv
// Two-entry queue between the front end and the divider back end.
module swp_fifo import swp_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  item_t data_i,
  output logic  full_o,
  input  logic  pop_i,
  output logic  vld_o,
  output item_t data_o
);

  item_t      mem_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;
  logic       do_push, do_pop;

  assign full_o  = cnt_q == 2'd2;
  assign vld_o   = cnt_q != 2'd0;
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && vld_o;
  assign data_o  = mem_q[rp_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (do_push) wp_q <= !wp_q;
      if (do_pop)  rp_q <= !rp_q;
      cnt_q <= cnt_q + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wp_q] <= data_i;
  end

endmodule

>>> hw/rtl/swp_back.sv
// Back end: pipelined row divider, grid window rules and the output register.
module swp_back import swp_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       vld_i,
  input  item_t      item_i,
  output logic       pop_o,
  swp_out_if.source  out_o
);

  // One quotient bit per divider stage; the dividend register fills with quotient bits.
  item_t             st_q  [DivW+1];
  logic [Lanes-1:0][FieldW-1:0] rem_q [DivW+1];
  logic [DivW:0]     vld_q;
  logic              en;

  logic              a_vld_q, a_zero_q, a_grid_q, a_rvz_q;
  logic [FieldW-1:0] a_list_q, a_cols_q;
  logic [DivW-1:0]   a_top_q;
  logic [DivW-1:0]   rv, ra, wr, sr, half, ftop, top, tmax;
  logic [DivW:0]     trv;
  logic [FieldW-1:0] res_q;
  logic [DivW+FieldW-1:0] prod;

  // The whole pipeline advances only while the output register can take a new value.
  assign en    = !out_o.valid || out_o.ready;
  assign pop_o = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[DivW-1:0], vld_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      st_q[0]  <= item_i;
      rem_q[0] <= '0;
    end
  end

  for (genvar g = 0; g < DivW; g++) begin : g_div
    always_ff @(posedge clk_i) begin
      logic [FieldW:0]              r;
      item_t                        nxt;
      logic [Lanes-1:0][FieldW-1:0] rem;
      if (en) begin
        nxt = st_q[g];
        for (int l = 0; l < Lanes; l++) begin
          r = {rem_q[g][l], st_q[g].dvd[l][DivW-1]};
          if (r >= {1'b0, st_q[g].cols}) begin
            r = r - {1'b0, st_q[g].cols};
            nxt.dvd[l] = {st_q[g].dvd[l][DivW-2:0], 1'b1};
          end else begin
            nxt.dvd[l] = {st_q[g].dvd[l][DivW-2:0], 1'b0};
          end
          rem[l] = r[FieldW-1:0];
        end
        st_q[g+1]  <= nxt;
        rem_q[g+1] <= rem;
      end
    end
  end

  always_comb begin
    rv   = st_q[DivW].dvd[LaneCap];
    ra   = st_q[DivW].dvd[LaneCnt];
    wr   = st_q[DivW].dvd[LaneWin];
    sr   = st_q[DivW].dvd[LaneSel];
    half = rv >> 1;
    ftop = (sr > half) ? sr - half : '0;
    top  = st_q[DivW].op ? ftop : wr;
    trv  = {1'b0, top} + {1'b0, rv};
    if (sr < top) begin
      top = sr;
    end else if ({1'b0, sr} >= trv) begin
      top = sr - rv + DivW'(1);
    end
    tmax = (ra > rv) ? ra - rv : '0;
    if (top > tmax) top = tmax;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
      out_o.valid <= 1'b0;
    end else if (en) begin
      a_vld_q     <= vld_q[DivW];
      out_o.valid <= a_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      a_zero_q <= st_q[DivW].zero;
      a_grid_q <= st_q[DivW].grid;
      a_list_q <= st_q[DivW].list_res;
      a_cols_q <= st_q[DivW].cols;
      a_rvz_q  <= rv == '0;
      a_top_q  <= top;
    end
  end

  assign prod = a_top_q * a_cols_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      if (a_zero_q)      res_q <= '0;
      else if (!a_grid_q) res_q <= a_list_q;
      else if (a_rvz_q)  res_q <= '0;
      else               res_q <= prod[FieldW-1:0];
    end
  end

  assign out_o.new_window_start = res_q;

endmodule

>>> hw/rtl/scroll_window_position.sv
// Top level of the scroll window position block.
// Computes the first visible index of a list or grid viewport, one result per input beat.
// A new beat is taken every cycle while the receiver is not stalling; a beat passes the front
// register, the queue, a 17-stage restoring divider that forms the four row quotients, a grid
// rule stage and the output register with the row-to-index multiply.
module scroll_window_position import swp_pkg::*; #(
  parameter int unsigned IndexBits = IndexBitsDef
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  swp_in_if.sink    in_i,
  swp_out_if.source out_o
);

  logic  f_vld, q_full, q_vld, pop;
  item_t f_item, q_item;

  swp_front #(.IndexBits(IndexBits)) u_front (
    .clk_i, .rst_ni, .in_i, .vld_o(f_vld), .item_o(f_item), .take_i(!q_full)
  );

  swp_fifo u_fifo (
    .clk_i, .rst_ni, .push_i(f_vld), .data_i(f_item), .full_o(q_full),
    .pop_i(pop), .vld_o(q_vld), .data_o(q_item)
  );

  swp_back u_back (
    .clk_i, .rst_ni, .vld_i(q_vld), .item_i(q_item), .pop_o(pop), .out_o
  );

endmodule

>>> bench/swp_checker.sv
// Checker that predicts and compares the scroll window results.
module swp_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  swp_in_if.sink      in_mon,
  swp_out_if.sink     out_mon,
  output int          fail_count_o,
  output int          pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [15:0] start_q[$];
  int          fails;

  assign fail_count_o = fails;
  assign pending_o    = start_q.size();

  function automatic longint unsigned clamp_tail(longint unsigned first, longint unsigned cap,
                                                 longint unsigned cnt);
    if (cap == 0 || cnt <= cap) return 0;
    return (first > cnt - cap) ? cnt - cap : first;
  endfunction

  function automatic longint unsigned grid_top(longint unsigned win, longint unsigned sel,
                                               longint unsigned cap, longint unsigned cnt,
                                               longint unsigned cols);
    longint unsigned rows_vis, rows_all, top, sel_row, top_max;
    rows_vis = cap / cols;
    rows_all = (cnt + cols - 1) / cols;
    top      = win / cols;
    sel_row  = sel / cols;
    if (rows_vis == 0) return 0;
    if (sel_row < top) top = sel_row;
    else if (sel_row >= top + rows_vis) top = sel_row - rows_vis + 1;
    top_max = (rows_all > rows_vis) ? rows_all - rows_vis : 0;
    if (top > top_max) top = top_max;
    return top * cols;
  endfunction

  function automatic logic [15:0] window_start_for(logic op, longint unsigned win,
                                                   longint unsigned sel, longint unsigned cap,
                                                   longint unsigned cnt,
                                                   longint unsigned cols);
    longint unsigned res, half, top;
    if (cap == 0 || cnt == 0) return '0;
    if (sel >= cnt) sel = cnt - 1;
    if (op) begin
      if (cols > 1) begin
        half = (cap / cols) / 2;
        top  = (sel / cols > half) ? sel / cols - half : 0;
        res  = grid_top(top * cols, sel, cap, cnt, cols);
      end else if (sel < cap / 2) begin
        res = 0;
      end else begin
        res = clamp_tail(sel - cap / 2, cap, cnt);
      end
    end else if (cols > 1) begin
      res = grid_top(win, sel, cap, cnt, cols);
    end else if (sel < win) begin
      res = clamp_tail(sel, cap, cnt);
    end else if (sel >= win + cap) begin
      res = clamp_tail(sel - cap + 1, cap, cnt);
    end else begin
      res = clamp_tail(win, cap, cnt);
    end
    return res[15:0];
  endfunction

  task automatic report_mismatch(string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    fails++;
  endtask

  initial fails = 0;

  always @(posedge clk_i) begin
    logic [15:0] exp_start;
    if (rst_ni) begin
      if (out_mon.valid && out_mon.ready) begin
        if (start_q.size() == 0) begin
          report_mismatch($sformatf("unexpected beat %0d", out_mon.new_window_start));
        end else begin
          exp_start = start_q.pop_front();
          if (out_mon.new_window_start !== exp_start)
            report_mismatch($sformatf("new_window_start %0d, want %0d",
                                      out_mon.new_window_start, exp_start));
        end
      end
      if (in_mon.valid && in_mon.ready)
        start_q.push_back(window_start_for(in_mon.op, in_mon.window_start,
                                           in_mon.selected_index, in_mon.capacity,
                                           in_mon.item_count, in_mon.column_count));
    end
  end
endmodule

>>> bench/testbench.sv
// Top of the scroll window testbench: clock, reset, stimulus and verdict.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int Latency = 21;
  localparam int IdleLimit = 5000;
  localparam int HoldCycles = 200;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  int   fail_count, pending;
  int   idle_cycles = 0;
  int   hold_left = 0;

  swp_in_if  in_ch();
  swp_out_if out_ch();

  scroll_window_position dut (.clk_i, .rst_ni, .in_i(in_ch), .out_o(out_ch));
  swp_checker chk (.clk_i, .rst_ni, .in_mon(in_ch), .out_mon(out_ch),
                   .fail_count_o(fail_count), .pending_o(pending));

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  initial begin
    in_ch.valid = 1'b0;
    in_ch.op = 1'b0;
    in_ch.window_start = '0;
    in_ch.selected_index = '0;
    in_ch.capacity = '0;
    in_ch.item_count = '0;
    in_ch.column_count = '0;
    out_ch.ready = 1'b0;
  end

  // Receiver stalls on its own pattern; one long hold-off fills the pipeline.
  always @(posedge clk_i) begin
    int mode;
    if (!rst_ni) out_ch.ready <= 1'b0;
    else if (hold_left > 0) begin
      out_ch.ready <= 1'b0;
      hold_left    <= hold_left - 1;
    end else begin
      mode = int'($realtime / 400.0);
      case (mode % 3)
        0:       out_ch.ready <= 1'b1;
        1:       out_ch.ready <= ($urandom_range(3) != 0);
        default: out_ch.ready <= ($urandom_range(2) == 0);
      endcase
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IdleLimit) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  function automatic logic [15:0] pick_field();
    case ($urandom_range(5))
      0:       return 16'hFFFF;
      1:       return '0;
      2:       return 16'($urandom_range(8));
      3:       return 16'($urandom_range(300));
      4:       return 16'($urandom_range(4000));
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic send_item(logic op, logic [15:0] win, logic [15:0] sel, logic [15:0] cap,
                           logic [15:0] cnt, logic [15:0] cols);
    in_ch.valid          <= 1'b1;
    in_ch.op             <= op;
    in_ch.window_start   <= win;
    in_ch.selected_index <= sel;
    in_ch.capacity       <= cap;
    in_ch.item_count     <= cnt;
    in_ch.column_count   <= cols;
    do @(posedge clk_i); while (!in_ch.ready);
  endtask

  task automatic send_random();
    logic [15:0] cnt, cap, cols;
    cnt = pick_field();
    cap = ($urandom_range(3) == 0) ? pick_field()
          : 16'($urandom_range((cnt < 16'd2) ? 32'd2 : 32'(cnt / 16'd2) + 32'd1));
    cols = ($urandom_range(1) == 0) ? 16'($urandom_range(1)) :
           (($urandom_range(4) == 0) ? pick_field() : 16'($urandom_range(12)));
    send_item(1'($urandom_range(1)), ($urandom_range(3) == 0) ? pick_field()
              : 16'($urandom_range(32'(cnt))), ($urandom_range(4) == 0) ? pick_field()
              : 16'($urandom_range(32'(cnt))), cap, cnt, cols);
  endtask

  task automatic pause(int cycles);
    in_ch.valid <= 1'b0;
    repeat (cycles) @(posedge clk_i);
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    // Directed beats: empty cases, list fit, tail clamp, grids, extremes.
    send_item(1'b0, 16'd5, 16'd3, 16'd0, 16'd10, 16'd1);
    send_item(1'b1, 16'd5, 16'd3, 16'd4, 16'd0, 16'd0);
    send_item(1'b0, 16'd0, 16'd50, 16'd4, 16'd10, 16'd0);
    send_item(1'b0, 16'd0, 16'd3, 16'd20, 16'd10, 16'd1);
    send_item(1'b0, 16'd9, 16'd9, 16'd4, 16'd10, 16'd1);
    send_item(1'b0, 16'd8, 16'd2, 16'd4, 16'd10, 16'd1);
    send_item(1'b0, 16'd0, 16'd7, 16'd4, 16'd10, 16'd1);
    send_item(1'b1, 16'd0, 16'd1, 16'd6, 16'd20, 16'd0);
    send_item(1'b1, 16'd0, 16'd15, 16'd6, 16'd20, 16'd1);
    send_item(1'b0, 16'd0, 16'd7, 16'd3, 16'd20, 16'd4);
    send_item(1'b0, 16'd0, 16'd17, 16'd12, 16'd19, 16'd4);
    send_item(1'b1, 16'd0, 16'd17, 16'd12, 16'd30, 16'd4);
    send_item(1'b1, 16'd0, 16'd1, 16'd12, 16'd30, 16'd4);
    send_item(1'b0, 16'd40, 16'd2, 16'd12, 16'd30, 16'd3);
    send_item(1'b0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_item(1'b1, 16'hFFFF, 16'hFFFF, 16'd1, 16'hFFFF, 16'd0);
    send_item(1'b0, 16'd0, 16'hFFFF, 16'd1, 16'hFFFF, 16'd1);
    send_item(1'b1, 16'hFFFF, 16'hFFFE, 16'hFFFE, 16'hFFFF, 16'd2);
    send_item(1'b0, 16'hFFFF, 16'd0, 16'h8000, 16'hFFFF, 16'h7FFF);
    send_item(1'b1, 16'hAAAA, 16'h5555, 16'd100, 16'hFFFF, 16'd7);
    // Sender pauses until every expected beat has come back.
    in_ch.valid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    // Long receiver hold-off, counted by the receiver, while beats keep coming.
    hold_left <= HoldCycles;
    repeat (60) send_random();
    for (int n = 0; n < 1750;) begin
      int burst;
      burst = $urandom_range(40, 1);
      for (int k = 0; k < burst; k++) send_random();
      n += burst;
      if ($urandom_range(2) == 0) pause($urandom_range(30, 1));
    end
    in_ch.valid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (Latency + 5) @(posedge clk_i);
    if (fail_count == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end
endmodule
